/* sv/hpfc_pkg.sv */
// ----------------------------------------------------------------------------
// hpfc_pkg
// Types and constants shared by the half precision converter stages.
// ----------------------------------------------------------------------------
package hpfc_pkg;

    typedef enum logic [1:0] {
        MODE_S2H = 2'd0,
        MODE_D2H = 2'd1,
        MODE_H2S = 2'd2,
        MODE_H2D = 2'd3
    } mode_t;

    // binary64 exponent limits for narrowing
    localparam logic [10:0] EXP_MAX      = 11'h7ff;
    localparam logic [10:0] EXP_OVF      = 11'd1039;
    localparam logic [10:0] EXP_DEN      = 11'd1008;
    localparam logic [10:0] EXP_ZERO     = 11'd998;
    localparam logic [10:0] EXP_NORM_OFS = 11'd1009;
    localparam logic [10:0] EXP_DEN_SH   = 11'd1051;
    localparam logic [10:0] EXP_S2D_OFS  = 11'd896;
    localparam logic [5:0]  NORM_SHIFT   = 6'd42;

    localparam logic [14:0] HALF_INF     = 15'h7c00;

    // widening exponent offsets
    localparam logic [7:0]  S_DEN_OFS    = 8'd103;
    localparam logic [7:0]  S_NORM_OFS   = 8'd112;
    localparam logic [10:0] D_DEN_OFS    = 11'd999;
    localparam logic [10:0] D_NORM_OFS   = 11'd1008;

    typedef struct packed {
        logic        fixed;      // result settled in decode
        logic [63:0] fixed_res;
        logic        fixed_ovf;
        logic        fixed_unf;
        logic        sgn;
        logic        unf;
        logic [52:0] sig;
        logic [5:0]  shamt;
        logic [4:0]  ebase;
    } s1_t;

    typedef struct packed {
        logic        fixed;
        logic [63:0] fixed_res;
        logic        fixed_ovf;
        logic        fixed_unf;
        logic        sgn;
        logic        unf;
        logic [10:0] kept;
        logic        guard;
        logic        sticky;
        logic [4:0]  ebase;
    } s2_t;

    typedef struct packed {
        logic [63:0] res;
        logic        ovf;
        logic        unf;
    } out_t;

endpackage

/* sv/hpfc_decode.sv */
// ----------------------------------------------------------------------------
// hpfc_decode
// Stage 1: classifies the source, settles specials and widening results,
// and sets up the rounding shift for narrowing.
// ----------------------------------------------------------------------------
module hpfc_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                in_valid,
    input  hpfc_pkg::mode_t     mode,
    input  logic [63:0]         source_bits,
    output logic                valid_reg,
    output hpfc_pkg::s1_t       data_reg
);

    hpfc_pkg::s1_t data_next;

    logic        sgn;
    logic [10:0] e;
    logic [51:0] man;
    logic [7:0]  fe;
    logic [9:0]  nan_m;
    logic        hs;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [3:0]  p;
    logic [9:0]  nm;
    logic [9:0]  wm;
    logic [7:0]  exp_s;
    logic [10:0] exp_d;

    always_comb
    begin
        // binary32 is re-expressed as binary64 first
        fe = source_bits[30:23];
        if (mode == hpfc_pkg::MODE_S2H)
        begin
            sgn = source_bits[31];
            man = {source_bits[22:0], 29'd0};
            if (fe == 8'd0)
                e = 11'd0;
            else if (fe == 8'hff)
                e = hpfc_pkg::EXP_MAX;
            else
                e = 11'(fe) + hpfc_pkg::EXP_S2D_OFS;
        end
        else
        begin
            sgn = source_bits[63];
            e   = source_bits[62:52];
            man = source_bits[51:0];
        end
        nan_m = man[51:42];

        // half leading-one search for denormal widening
        hs = source_bits[15];
        he = source_bits[14:10];
        hm = source_bits[9:0];
        p  = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (hm[i])
                p = 4'(i);
        end
        nm = 10'(hm << (4'd10 - p));
        wm = (he == 5'd0) ? nm : hm;

        if (he == 5'd0)
        begin
            exp_s = hpfc_pkg::S_DEN_OFS + 8'(p);
            exp_d = hpfc_pkg::D_DEN_OFS + 11'(p);
        end
        else if (he == 5'h1f)
        begin
            exp_s = 8'hff;
            exp_d = hpfc_pkg::EXP_MAX;
        end
        else
        begin
            exp_s = hpfc_pkg::S_NORM_OFS + 8'(he);
            exp_d = hpfc_pkg::D_NORM_OFS + 11'(he);
        end

        data_next           = '0;
        data_next.fixed     = 1'b1;
        data_next.sgn       = sgn;
        data_next.sig       = {1'b1, man};
        data_next.shamt     = hpfc_pkg::NORM_SHIFT;

        case (mode)
            hpfc_pkg::MODE_S2H, hpfc_pkg::MODE_D2H:
            begin
                if (e >= hpfc_pkg::EXP_OVF)
                begin
                    data_next.fixed_res = {48'd0, sgn, hpfc_pkg::HALF_INF};
                    if (e == hpfc_pkg::EXP_MAX)
                    begin
                        if (man != '0)
                            data_next.fixed_res[9:0] = (nan_m == '0) ? 10'd1 : nan_m;
                    end
                    else
                        data_next.fixed_ovf = 1'b1;
                end
                else if (e <= hpfc_pkg::EXP_DEN)
                begin
                    if (e < hpfc_pkg::EXP_ZERO)
                    begin
                        data_next.fixed_res = {48'd0, sgn, 15'd0};
                        data_next.fixed_unf = (e != 11'd0) || (man != '0);
                    end
                    else
                    begin
                        data_next.fixed = 1'b0;
                        data_next.unf   = 1'b1;
                        data_next.shamt = 6'(hpfc_pkg::EXP_DEN_SH - e);
                        data_next.ebase = 5'd0;
                    end
                end
                else
                begin
                    data_next.fixed = 1'b0;
                    data_next.ebase = 5'(e - hpfc_pkg::EXP_NORM_OFS);
                end
            end
            hpfc_pkg::MODE_H2S:
            begin
                if (he == 5'd0 && hm == 10'd0)
                    data_next.fixed_res = {32'd0, hs, 31'd0};
                else
                    data_next.fixed_res = {32'd0, hs, exp_s, wm, 13'd0};
            end
            default:
            begin
                if (he == 5'd0 && hm == 10'd0)
                    data_next.fixed_res = {hs, 63'd0};
                else
                    data_next.fixed_res = {hs, exp_d, wm, 42'd0};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

endmodule

/* sv/hpfc_shift.sv */
// ----------------------------------------------------------------------------
// hpfc_shift
// Stage 2: aligns the significand and extracts guard and sticky bits.
// ----------------------------------------------------------------------------
module hpfc_shift (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                in_valid,
    input  hpfc_pkg::s1_t       in_data,
    output logic                valid_reg,
    output hpfc_pkg::s2_t       data_reg
);

    hpfc_pkg::s2_t data_next;

    logic [52:0] shifted;
    logic [52:0] gtmp;
    logic [52:0] mask;
    logic [5:0]  gidx;

    always_comb
    begin
        gidx    = in_data.shamt - 6'd1;
        shifted = in_data.sig >> in_data.shamt;
        gtmp    = in_data.sig >> gidx;
        mask    = (53'd1 << gidx) - 53'd1;

        data_next           = '0;
        data_next.fixed     = in_data.fixed;
        data_next.fixed_res = in_data.fixed_res;
        data_next.fixed_ovf = in_data.fixed_ovf;
        data_next.fixed_unf = in_data.fixed_unf;
        data_next.sgn       = in_data.sgn;
        data_next.unf       = in_data.unf;
        data_next.ebase     = in_data.ebase;
        data_next.kept      = shifted[10:0];
        data_next.guard     = gtmp[0];
        data_next.sticky    = |(in_data.sig & mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

endmodule

/* sv/hpfc_pack.sv */
// ----------------------------------------------------------------------------
// hpfc_pack
// Stage 3: round increment, exponent carry and overflow, output register.
// ----------------------------------------------------------------------------
module hpfc_pack (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                in_valid,
    input  logic                ties_even,
    input  hpfc_pkg::s2_t       in_data,
    output logic                valid_reg,
    output hpfc_pkg::out_t      data_reg
);

    hpfc_pkg::out_t data_next;

    logic        up;
    logic [15:0] sum;

    always_comb
    begin
        up  = in_data.guard & (in_data.sticky | in_data.kept[0] | ~ties_even);
        sum = 16'({in_data.ebase, 10'd0}) + 16'(in_data.kept) + 16'(up);

        data_next = '0;
        if (in_data.fixed)
        begin
            data_next.res = in_data.fixed_res;
            data_next.ovf = in_data.fixed_ovf;
            data_next.unf = in_data.fixed_unf;
        end
        else
        begin
            data_next.unf = in_data.unf;
            // mantissa carry may walk into the infinity exponent
            if (sum >= 16'(hpfc_pkg::HALF_INF))
            begin
                data_next.ovf = 1'b1;
                data_next.res = {48'd0, in_data.sgn, hpfc_pkg::HALF_INF};
            end
            else
                data_next.res = {48'd0, in_data.sgn, sum[14:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

endmodule

/* sv/half_precision_format_converter.sv */
// ----------------------------------------------------------------------------
// half_precision_format_converter
// Converts binary32/binary64 to binary16 and back, one transaction per cycle.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata carries the source pattern, s_axis_tuser the
// mode (0 single->half, 1 double->half, 2 half->single, 3 half->double).
// Output stream: m_axis_tdata carries the right aligned result, m_axis_tuser
// the overflow and underflow flags.
// cfg_wr_en/cfg_wr_data write the rounding control (1 ties to even, 0 ties
// away); change it only while the pipeline is empty.
// An input transaction passes three register stages to output valid: decode,
// align, and round/pack. Throughput is one transaction per cycle unless the
// receiver stalls, set by the three-stage pipeline with no iterative unit.
// Every stage has its own valid bit and a stage loads whenever it is empty
// or the stage behind it moves, so bubbles close up under back-pressure.
// When the receiver stalls, the output register holds its transaction and
// up to two more are taken before s_axis_tready falls.
// Reset clears all valid bits and sets rounding to ties to even.
// ----------------------------------------------------------------------------
module half_precision_format_converter (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // round_ties_even

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] source_bits
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] result_bits
    output logic [1:0]  m_axis_tuser    // [0] overflow_flag, [1] underflow_flag
);

    logic           round_ties_even_reg;
    logic           v1, v2, v3;
    logic           rdy1, rdy2, rdy3;
    hpfc_pkg::s1_t  s1;
    hpfc_pkg::s2_t  s2;
    hpfc_pkg::out_t s3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            round_ties_even_reg <= 1'b1;
        else if (cfg_wr_en)
            round_ties_even_reg <= cfg_wr_data;
    end

    assign rdy3 = !v3 || m_axis_tready;
    assign rdy2 = !v2 || rdy3;
    assign rdy1 = !v1 || rdy2;
    assign s_axis_tready = rdy1;

    hpfc_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (rdy1),
        .in_valid    (s_axis_tvalid),
        .mode        (hpfc_pkg::mode_t'(s_axis_tuser)),
        .source_bits (s_axis_tdata),
        .valid_reg   (v1),
        .data_reg    (s1)
    );

    hpfc_shift u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rdy2),
        .in_valid  (v1),
        .in_data   (s1),
        .valid_reg (v2),
        .data_reg  (s2)
    );

    hpfc_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rdy3),
        .in_valid  (v2),
        .ties_even (round_ties_even_reg),
        .in_data   (s2),
        .valid_reg (v3),
        .data_reg  (s3)
    );

    assign m_axis_tvalid = v3;
    assign m_axis_tdata  = s3.res;
    assign m_axis_tuser  = {s3.unf, s3.ovf};

    // an empty output register must never block the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v3 |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // overflow always yields half infinity
    a_ovf_is_inf: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[14:0] == hpfc_pkg::HALF_INF))
        else $error("overflow without infinity result");

    // flags are exclusive
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("overflow and underflow both set");

    // underflow results lie at or below the smallest normal
    a_unf_small: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[14:0] <= 15'h0400))
        else $error("underflow flag on a large result");

endmodule
